// ----- src/rotation_matrix_to_quaternion_defines.svh -----
// Assertion macros shared by the rotation matrix to quaternion RTL.
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RMQ_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define RMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/rmq_pkg.sv -----
// Shared types and constants of the rotation matrix to quaternion block.
package rmq_pkg;

   localparam int ElemWidth  = 16;
   localparam int DWidth     = 17;
   localparam int DivWidth   = 48;
   localparam int DivSteps   = DivWidth;
   localparam int SqrtSteps  = DivWidth / 2;
   localparam int RootWidth  = SqrtSteps;
   localparam int RemWidth   = RootWidth + 2;
   localparam int Lanes      = 4;

   localparam logic [1:0] BranchTrace = 2'd0;
   localparam logic [1:0] BranchX     = 2'd1;
   localparam logic [1:0] BranchY     = 2'd2;
   localparam logic [1:0] BranchZ     = 2'd3;

   typedef struct packed {
      logic               valid;
      logic [1:0]         branch;
      logic               degen;
      logic [Lanes-1:0]   neg;
      logic [DWidth-1:0]  d;
   } side_type;

endpackage

// ----- src/rmq_front.sv -----
// Branch selection, square-root argument and squared numerators for each item.
module rmq_front (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               take,
   input  logic [8:0][rmq_pkg::ElemWidth-1:0]                 mat,
   output rmq_pkg::side_type                                  side_out,
   output logic [rmq_pkg::Lanes-1:0][rmq_pkg::DivWidth-1:0]   dividend_out
);

   logic signed [15:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
   logic signed [17:0] trace;
   logic signed [18:0] d_sel;
   logic signed [16:0] n_21m12, n_02m20, n_10m01, p_01a10, p_02a20, p_12a21;
   logic signed [16:0] num [rmq_pkg::Lanes];
   logic [1:0]  branch;
   logic        x_big, y_big;

   logic                                           valid_a_ff, valid_a_in;
   logic [1:0]                                     branch_a_ff;
   logic                                           degen_a_ff;
   logic [rmq_pkg::Lanes-1:0]                      neg_a_ff, neg_a_in;
   logic [rmq_pkg::DWidth-1:0]                     d_a_ff, d_a_in;
   logic [rmq_pkg::Lanes-1:0][16:0]                mag_a_ff, mag_a_in;
   rmq_pkg::side_type                              side_ff, side_in;
   logic [rmq_pkg::Lanes-1:0][rmq_pkg::DivWidth-1:0] dividend_ff, dividend_in;
   logic [16:0] abs_n [rmq_pkg::Lanes];
   logic [33:0] sq [rmq_pkg::Lanes];

   always_comb begin
      a00 = mat[0]; a01 = mat[1]; a02 = mat[2];
      a10 = mat[3]; a11 = mat[4]; a12 = mat[5];
      a20 = mat[6]; a21 = mat[7]; a22 = mat[8];
      trace = {{2{a00[15]}}, a00} + {{2{a11[15]}}, a11} + {{2{a22[15]}}, a22};
      x_big = (a00 > a11) && (a00 > a22);
      y_big = a11 > a22;
      n_21m12 = {a21[15], a21} - {a12[15], a12};
      n_02m20 = {a02[15], a02} - {a20[15], a20};
      n_10m01 = {a10[15], a10} - {a01[15], a01};
      p_01a10 = {a01[15], a01} + {a10[15], a10};
      p_02a20 = {a02[15], a02} + {a20[15], a20};
      p_12a21 = {a12[15], a12} + {a21[15], a21};
      for (int j = 0; j < rmq_pkg::Lanes; j++) begin
         num[j] = '0;
      end
      if (trace > 18'sd0) begin
         branch = rmq_pkg::BranchTrace;
         d_sel  = {trace[17], trace} + 19'sd16384;
         num[1] = n_21m12; num[2] = n_02m20; num[3] = n_10m01;
      end else if (x_big) begin
         branch = rmq_pkg::BranchX;
         d_sel  = 19'sd16384 + {{3{a00[15]}}, a00} - {{3{a11[15]}}, a11}
                  - {{3{a22[15]}}, a22};
         num[0] = n_21m12; num[2] = p_01a10; num[3] = p_02a20;
      end else if (y_big) begin
         branch = rmq_pkg::BranchY;
         d_sel  = 19'sd16384 + {{3{a11[15]}}, a11} - {{3{a00[15]}}, a00}
                  - {{3{a22[15]}}, a22};
         num[0] = n_02m20; num[1] = p_01a10; num[3] = p_12a21;
      end else begin
         branch = rmq_pkg::BranchZ;
         d_sel  = 19'sd16384 + {{3{a22[15]}}, a22} - {{3{a00[15]}}, a00}
                  - {{3{a11[15]}}, a11};
         num[0] = n_10m01; num[1] = p_02a20; num[2] = p_12a21;
      end
      valid_a_in = take;
      // keep a harmless divisor for degenerate items; their outputs are forced to zero
      d_a_in = (d_sel <= 19'sd0) ? rmq_pkg::DWidth'(1) : d_sel[rmq_pkg::DWidth-1:0];
      for (int j = 0; j < rmq_pkg::Lanes; j++) begin
         neg_a_in[j] = num[j][16];
         abs_n[j]    = num[j][16] ? 17'(-num[j]) : 17'(num[j]);
         mag_a_in[j] = abs_n[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else begin
         valid_a_ff <= valid_a_in;
      end
      branch_a_ff <= branch;
      degen_a_ff  <= d_sel <= 19'sd0;
      neg_a_ff    <= neg_a_in;
      d_a_ff      <= d_a_in;
      mag_a_ff    <= mag_a_in;
   end

   always_comb begin
      side_in.valid  = valid_a_ff;
      side_in.branch = branch_a_ff;
      side_in.degen  = degen_a_ff;
      side_in.neg    = neg_a_ff;
      side_in.d      = d_a_ff;
      for (int j = 0; j < rmq_pkg::Lanes; j++) begin
         sq[j] = {17'b0, mag_a_ff[j]} * {17'b0, mag_a_ff[j]};
         dividend_in[j] = {sq[j], 14'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= '0;
      end else begin
         side_ff <= side_in;
      end
      dividend_ff <= dividend_in;
   end

   assign side_out     = side_ff;
   assign dividend_out = dividend_ff;

endmodule

// ----- src/rmq_div_cell.sv -----
// One restoring division step: consumes a dividend bit, shifts in a quotient bit.
module rmq_div_cell (
   input  logic                           clock,
   input  logic [rmq_pkg::DWidth-1:0]     divisor,
   input  logic [rmq_pkg::DivWidth-1:0]   x_in,
   input  logic [rmq_pkg::DWidth-1:0]     r_in,
   output logic [rmq_pkg::DivWidth-1:0]   x_out,
   output logic [rmq_pkg::DWidth-1:0]     r_out
);

   logic [rmq_pkg::DWidth:0]     cur, diff;
   logic                         ge;
   logic [rmq_pkg::DivWidth-1:0] x_ff, x_in_next;
   logic [rmq_pkg::DWidth-1:0]   r_ff, r_in_next;

   always_comb begin
      cur  = {r_in, x_in[rmq_pkg::DivWidth-1]};
      diff = cur - {1'b0, divisor};
      ge   = cur >= {1'b0, divisor};
      r_in_next = ge ? diff[rmq_pkg::DWidth-1:0] : cur[rmq_pkg::DWidth-1:0];
      x_in_next = {x_in[rmq_pkg::DivWidth-2:0], ge};
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in_next;
      r_ff <= r_in_next;
   end

   assign x_out = x_ff;
   assign r_out = r_ff;

endmodule

// ----- src/rmq_sqrt_cell.sv -----
// One digit of a restoring integer square root: two radicand bits in, one root bit out.
module rmq_sqrt_cell (
   input  logic                           clock,
   input  logic [rmq_pkg::DivWidth-1:0]   v_in,
   input  logic [rmq_pkg::RemWidth-1:0]   rem_in,
   input  logic [rmq_pkg::RootWidth-1:0]  root_in,
   output logic [rmq_pkg::DivWidth-1:0]   v_out,
   output logic [rmq_pkg::RemWidth-1:0]   rem_out,
   output logic [rmq_pkg::RootWidth-1:0]  root_out
);

   logic [rmq_pkg::RemWidth+1:0]  cur, trial, diff;
   logic                          ge;
   logic [rmq_pkg::DivWidth-1:0]  v_ff;
   logic [rmq_pkg::RemWidth-1:0]  rem_ff, rem_in_next;
   logic [rmq_pkg::RootWidth-1:0] root_ff, root_in_next;

   always_comb begin
      cur   = {rem_in, v_in[rmq_pkg::DivWidth-1 -: 2]};
      trial = {2'b0, root_in, 2'b01};
      diff  = cur - trial;
      ge    = cur >= trial;
      rem_in_next  = ge ? diff[rmq_pkg::RemWidth-1:0] : cur[rmq_pkg::RemWidth-1:0];
      root_in_next = {root_in[rmq_pkg::RootWidth-2:0], ge};
   end

   always_ff @(posedge clock) begin
      v_ff    <= {v_in[rmq_pkg::DivWidth-3:0], 2'b00};
      rem_ff  <= rem_in_next;
      root_ff <= root_in_next;
   end

   assign v_out    = v_ff;
   assign rem_out  = rem_ff;
   assign root_out = root_ff;

endmodule

// ----- src/rotation_matrix_to_quaternion.sv -----
// Rotation matrix to quaternion converter: pipeline of division and square-root cells.
//
// Usage:
//   Drive the nine Q2.14 matrix elements on req_m_r*c* and raise start for one
//   cycle per item. busy is always low, so an item is taken every cycle.
//   Each item passes through 2 front stages (branch select, squaring),
//   48 division cells, 24 square-root cells and one output register.
//   rsp_valid marks the item for exactly one cycle on
//   rsp_quat_*, rsp_branch_taken and rsp_degenerate.
//   Throughput is one item per cycle; every cell hands its partial result to
//   its neighbor on each clock, so every stage, cell and register can hold an item.
//   The receiver cannot hold items off; results are never stalled.
//   Synchronous reset clears all valid flags; items in flight are dropped.
//   Degenerate matrices give a zero quaternion with rsp_degenerate set.
`include "rotation_matrix_to_quaternion_defines.svh"

module rotation_matrix_to_quaternion (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_m_r0c0,
   input  logic signed [15:0] req_m_r0c1,
   input  logic signed [15:0] req_m_r0c2,
   input  logic signed [15:0] req_m_r1c0,
   input  logic signed [15:0] req_m_r1c1,
   input  logic signed [15:0] req_m_r1c2,
   input  logic signed [15:0] req_m_r2c0,
   input  logic signed [15:0] req_m_r2c1,
   input  logic signed [15:0] req_m_r2c2,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_quat_w,
   output logic signed [15:0] rsp_quat_x,
   output logic signed [15:0] rsp_quat_y,
   output logic signed [15:0] rsp_quat_z,
   output logic [1:0]         rsp_branch_taken,
   output logic               rsp_degenerate
);

   localparam int Stages  = rmq_pkg::DivSteps + rmq_pkg::SqrtSteps;
   localparam int Latency = 2 + Stages + 1;

   logic [8:0][15:0] mat;
   rmq_pkg::side_type side [Stages+1];
   logic [rmq_pkg::Lanes-1:0][rmq_pkg::DivWidth-1:0] dividend;

   logic [rmq_pkg::DivWidth-1:0]  div_x   [rmq_pkg::Lanes][rmq_pkg::DivSteps+1];
   logic [rmq_pkg::DWidth-1:0]    div_r   [rmq_pkg::Lanes][rmq_pkg::DivSteps+1];
   logic [rmq_pkg::DivWidth-1:0]  sq_v    [rmq_pkg::Lanes][rmq_pkg::SqrtSteps+1];
   logic [rmq_pkg::RemWidth-1:0]  sq_rem  [rmq_pkg::Lanes][rmq_pkg::SqrtSteps+1];
   logic [rmq_pkg::RootWidth-1:0] sq_root [rmq_pkg::Lanes][rmq_pkg::SqrtSteps+1];

   logic [rmq_pkg::Lanes-1:0][15:0] q_in;
   logic [rmq_pkg::Lanes-1:0][15:0] q_ff;
   logic                            valid_ff;
   logic [1:0]                      branch_ff;
   logic                            degen_ff;
   logic [rmq_pkg::RootWidth:0]     rsum [rmq_pkg::Lanes];
   logic [rmq_pkg::RootWidth-1:0]   k    [rmq_pkg::Lanes];

   assign busy = 1'b0;
   assign mat = {req_m_r2c2, req_m_r2c1, req_m_r2c0, req_m_r1c2, req_m_r1c1,
                 req_m_r1c0, req_m_r0c2, req_m_r0c1, req_m_r0c0};

   rmq_front u_front (
      .clock        (clock),
      .reset        (reset),
      .take         (start && !busy),
      .mat          (mat),
      .side_out     (side[0]),
      .dividend_out (dividend)
   );

   // sideband travels alongside the cells
   for (genvar i = 0; i < Stages; i++) begin : g_side
      always_ff @(posedge clock) begin
         if (reset) begin
            side[i+1] <= '0;
         end else begin
            side[i+1] <= side[i];
         end
      end
   end

   for (genvar j = 0; j < rmq_pkg::Lanes; j++) begin : g_lane
      assign div_x[j][0] = dividend[j];
      assign div_r[j][0] = '0;
      for (genvar i = 0; i < rmq_pkg::DivSteps; i++) begin : g_div
         rmq_div_cell u_div (
            .clock   (clock),
            .divisor (side[i].d),
            .x_in    (div_x[j][i]),
            .r_in    (div_r[j][i]),
            .x_out   (div_x[j][i+1]),
            .r_out   (div_r[j][i+1])
         );
      end
      // the diagonal lane takes the root of D scaled by 2^14 instead of a quotient
      assign sq_v[j][0] = (side[rmq_pkg::DivSteps].branch == 2'(j))
         ? {{(rmq_pkg::DivWidth-rmq_pkg::DWidth-14){1'b0}},
            side[rmq_pkg::DivSteps].d, 14'b0}
         : div_x[j][rmq_pkg::DivSteps];
      assign sq_rem[j][0]  = '0;
      assign sq_root[j][0] = '0;
      for (genvar s = 0; s < rmq_pkg::SqrtSteps; s++) begin : g_sqrt
         rmq_sqrt_cell u_sqrt (
            .clock    (clock),
            .v_in     (sq_v[j][s]),
            .rem_in   (sq_rem[j][s]),
            .root_in  (sq_root[j][s]),
            .v_out    (sq_v[j][s+1]),
            .rem_out  (sq_rem[j][s+1]),
            .root_out (sq_root[j][s+1])
         );
      end
   end

   // round half up on the doubled root, then saturate to Q2.14
   always_comb begin
      for (int j = 0; j < rmq_pkg::Lanes; j++) begin
         rsum[j] = {1'b0, sq_root[j][rmq_pkg::SqrtSteps]} + (rmq_pkg::RootWidth+1)'(1);
         k[j]    = rsum[j][rmq_pkg::RootWidth:1];
         if (side[Stages].degen) begin
            q_in[j] = '0;
         end else if (side[Stages].neg[j]) begin
            q_in[j] = (k[j] > rmq_pkg::RootWidth'(32768)) ? 16'h8000
                                                         : 16'(16'd0 - k[j][15:0]);
         end else begin
            q_in[j] = (k[j] > rmq_pkg::RootWidth'(32767)) ? 16'h7fff : k[j][15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= side[Stages].valid;
      end
      q_ff      <= q_in;
      branch_ff <= side[Stages].branch;
      degen_ff  <= side[Stages].degen;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_quat_w       = q_ff[0];
   assign rsp_quat_x       = q_ff[1];
   assign rsp_quat_y       = q_ff[2];
   assign rsp_quat_z       = q_ff[3];
   assign rsp_branch_taken = branch_ff;
   assign rsp_degenerate   = degen_ff;

   `RMQ_ASSERT_NOW(a_rsp_has_req, rsp_valid, $past(start, Latency), "item without request")
   `RMQ_ASSERT_NOW(a_degen_zero, rsp_valid && rsp_degenerate, q_ff == '0, "degenerate not zero")
   `RMQ_ASSERT_NOW(a_trace_ok, rsp_valid && rsp_branch_taken == rmq_pkg::BranchTrace, !rsp_degenerate, "trace branch degenerate")
   `RMQ_ASSERT_NEXT(a_pipe_valid, side[Stages].valid, rsp_valid, "item lost at output")

endmodule
